/* hdl/resizable_array_block_mapper_core_defines.svh */
// ---------------------------------------------------------------------------
// Resizable array block mapper: assertion macros
// Shared concurrent assertion forms, reset-qualified on the async reset.
// ---------------------------------------------------------------------------
`ifndef RESIZABLE_ARRAY_BLOCK_MAPPER_CORE_DEFINES_SVH
`define RESIZABLE_ARRAY_BLOCK_MAPPER_CORE_DEFINES_SVH

// same-cycle implication
`define RABM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define RABM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/rabm_pkg.sv */
// ---------------------------------------------------------------------------
// Resizable array block mapper: package
// Field widths, action/status/event codes and the front-to-back job record.
// ---------------------------------------------------------------------------
package rabm_pkg;

	localparam int POS_BITS  = 20;
	localparam int BLK_BITS  = 11;
	localparam int OFF_BITS  = 10;
	localparam int VAL_BITS  = 32;
	localparam int SIZE_BITS = 11;
	localparam int LVL_BITS  = 6;
	localparam int NBLK_BITS = 12;
	localparam int ACT_BITS  = 2;

	localparam logic [POS_BITS-1:0] CAPACITY = {POS_BITS{1'b1}};

	localparam logic [ACT_BITS-1:0] ACT_PUSH = 2'd0;
	localparam int ACT_LOCATE_BIT = 1;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		EV_NONE  = 2'd0,
		EV_ALLOC = 2'd1,
		EV_FREE  = 2'd2
	} alloc_t;

	typedef struct packed {
		logic                        do_map;
		logic [POS_BITS-1:0]         map_pos;
		logic signed [VAL_BITS-1:0]  value;
		alloc_t                      ev;
		logic [BLK_BITS-1:0]         ablk;
		logic [SIZE_BITS-1:0]        asize;
		logic [POS_BITS-1:0]         count;
		status_t                     status;
	} job_t;

endpackage

/* hdl/rabm_if.sv */
// ---------------------------------------------------------------------------
// Resizable array block mapper: channel interfaces
// Request channel (action in) and response channel (mapping out).
// ---------------------------------------------------------------------------
interface rabm_in_if;
	logic                                     valid;
	logic                                     ready;
	logic [rabm_pkg::ACT_BITS-1:0]            action;
	logic [rabm_pkg::POS_BITS-1:0]            position;
	logic signed [rabm_pkg::VAL_BITS-1:0]     write_value;

	modport source(output valid, output action, output position, output write_value,
		input ready);
	modport sink(input valid, input action, input position, input write_value,
		output ready);
endinterface

interface rabm_out_if;
	logic                                     valid;
	logic                                     ready;
	logic [rabm_pkg::BLK_BITS-1:0]            block_number;
	logic [rabm_pkg::OFF_BITS-1:0]            block_offset;
	logic signed [rabm_pkg::VAL_BITS-1:0]     value_out;
	logic [1:0]                               alloc_event;
	logic [rabm_pkg::BLK_BITS-1:0]            alloc_block;
	logic [rabm_pkg::SIZE_BITS-1:0]           alloc_size;
	logic [rabm_pkg::POS_BITS-1:0]            element_count;
	logic [1:0]                               status;

	modport source(output valid, output block_number, output block_offset,
		output value_out, output alloc_event, output alloc_block, output alloc_size,
		output element_count, output status, input ready);
	modport sink(input valid, input block_number, input block_offset,
		input value_out, input alloc_event, input alloc_block, input alloc_size,
		input element_count, input status, output ready);
endinterface

/* hdl/rabm_front.sv */
// ---------------------------------------------------------------------------
// Resizable array block mapper: front end
// Accepts actions, checks range, keeps the layout state and emits one job.
// ---------------------------------------------------------------------------
`include "resizable_array_block_mapper_core_defines.svh"

module rabm_front (
	input  logic              clk,
	input  logic              arst_n,
	rabm_in_if.sink           req,
	output logic              job_valid,
	input  logic              job_ready,
	output rabm_pkg::job_t    job
);

	localparam int PW = rabm_pkg::POS_BITS;
	localparam int BW = rabm_pkg::BLK_BITS;
	localparam int SW = rabm_pkg::SIZE_BITS;
	localparam int LW = rabm_pkg::LVL_BITS;
	localparam int NW = rabm_pkg::NBLK_BITS;

	logic [PW-1:0] count_q,    count_n;
	logic [LW-1:0] level_q,    level_n;
	logic [SW-1:0] blk_size_q, blk_size_n;
	logic [SW-1:0] blk_fill_q, blk_fill_n;
	logic [SW-1:0] sup_size_q, sup_size_n;
	logic [SW-1:0] sup_fill_q, sup_fill_n;
	logic [NW-1:0] nblk_q,     nblk_n;
	logic          spare_q,    spare_n;

	logic          fire;
	logic          is_push;
	logic [SW-1:0] bf;
	logic [SW-1:0] sf;

	assign is_push   = req.action == rabm_pkg::ACT_PUSH;
	assign job_valid = req.valid;
	assign req.ready = job_ready;
	assign fire      = req.valid && job_ready;

	always_comb begin
		count_n    = count_q;
		level_n    = level_q;
		blk_size_n = blk_size_q;
		blk_fill_n = blk_fill_q;
		sup_size_n = sup_size_q;
		sup_fill_n = sup_fill_q;
		nblk_n     = nblk_q;
		spare_n    = spare_q;
		bf         = blk_fill_q;
		sf         = sup_fill_q;

		job        = '0;
		job.ev     = rabm_pkg::EV_NONE;
		job.status = rabm_pkg::ST_OK;

		if (req.action[rabm_pkg::ACT_LOCATE_BIT]) begin
			if (req.position >= count_q) begin
				job.status = rabm_pkg::ST_RANGE;
			end else begin
				job.do_map  = 1'b1;
				job.map_pos = req.position;
			end
		end else if (is_push) begin
			if (count_q == rabm_pkg::CAPACITY) begin
				job.status = rabm_pkg::ST_FULL;
			end else begin
				if (blk_fill_q >= blk_size_q) begin
					if (sup_fill_q >= sup_size_q) begin
						level_n = level_q + 1'b1;
						if (level_n[0]) begin
							sup_size_n = sup_size_q << 1;
						end else begin
							blk_size_n = blk_size_q << 1;
						end
						sf = '0;
					end
					if (!spare_q) begin
						job.ev    = rabm_pkg::EV_ALLOC;
						job.ablk  = nblk_q[BW-1:0];
						job.asize = blk_size_n;
					end else begin
						spare_n = 1'b0;
					end
					nblk_n     = nblk_q + 1'b1;
					sup_fill_n = sf + 1'b1;
					bf         = '0;
				end
				count_n     = count_q + 1'b1;
				blk_fill_n  = bf + 1'b1;
				job.do_map  = 1'b1;
				job.map_pos = count_q;
				job.value   = req.write_value;
			end
		end else begin
			if (count_q == '0) begin
				job.status = rabm_pkg::ST_EMPTY;
			end else begin
				job.do_map  = 1'b1;
				job.map_pos = count_q - 1'b1;
				count_n     = count_q - 1'b1;
				bf          = blk_fill_q - 1'b1;
				if (bf == '0) begin
					if (spare_q) begin
						job.ev   = rabm_pkg::EV_FREE;
						job.ablk = nblk_q[BW-1:0];
					end
					nblk_n  = nblk_q - 1'b1;
					sf      = sup_fill_q - 1'b1;
					spare_n = 1'b1;
					if (level_q > LW'(1) && sf == '0) begin
						level_n = level_q - 1'b1;
						if (level_n[0]) begin
							blk_size_n = blk_size_q >> 1;
						end else begin
							sup_size_n = sup_size_q >> 1;
						end
						sf = sup_size_n;
					end
					sup_fill_n = sf;
					bf         = blk_size_n;
				end
				blk_fill_n = bf;
			end
		end
		job.count = count_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			level_q    <= LW'(1);
			blk_size_q <= SW'(1);
			blk_fill_q <= SW'(1);
			sup_size_q <= SW'(1);
			sup_fill_q <= '0;
			nblk_q     <= '0;
			spare_q    <= 1'b0;
		end else if (fire) begin
			count_q    <= count_n;
			level_q    <= level_n;
			blk_size_q <= blk_size_n;
			blk_fill_q <= blk_fill_n;
			sup_size_q <= sup_size_n;
			sup_fill_q <= sup_fill_n;
			nblk_q     <= nblk_n;
			spare_q    <= spare_n;
		end
	end

	`RABM_ASSERT_NEXT(a_push_grows, clk, arst_n, fire && is_push && !req.action[1] && job.status == rabm_pkg::ST_OK, count_q == $past(count_q) + 1'b1, "push did not grow count")
	`RABM_ASSERT_NEXT(a_err_holds, clk, arst_n, fire && job.status != rabm_pkg::ST_OK, $stable(count_q) && $stable(nblk_q) && $stable(spare_q), "rejected item changed layout")

endmodule

/* hdl/rabm_queue.sv */
// ---------------------------------------------------------------------------
// Resizable array block mapper: job queue
// Small FIFO decoupling the front end from the mapping back end.
// ---------------------------------------------------------------------------
`include "resizable_array_block_mapper_core_defines.svh"

module rabm_queue #(
	parameter int DEPTH = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push_valid,
	output logic              push_ready,
	input  rabm_pkg::job_t    push_job,
	output logic              pop_valid,
	input  logic              pop_ready,
	output rabm_pkg::job_t    pop_job
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	rabm_pkg::job_t mem_q [DEPTH];
	logic [AW-1:0]  wr_q;
	logic [AW-1:0]  rd_q;
	logic [CW-1:0]  cnt_q;
	logic           push;
	logic           pop;

	assign push_ready = cnt_q != CW'(DEPTH);
	assign pop_valid  = cnt_q != '0;
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_job    = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	`RABM_ASSERT_NOW(a_cnt_bound, clk, arst_n, 1'b1, cnt_q <= CW'(DEPTH), "queue count past depth")
	`RABM_ASSERT_NEXT(a_cnt_step, clk, arst_n, push && !pop, cnt_q == $past(cnt_q) + 1'b1, "queue count lost a push")

endmodule

/* hdl/rabm_back.sv */
// ---------------------------------------------------------------------------
// Resizable array block mapper: back end
// MSB split of position + 1 into block and offset; registered result.
// ---------------------------------------------------------------------------
module rabm_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              job_valid,
	output logic              job_ready,
	input  rabm_pkg::job_t    job,
	rabm_out_if.source        rsp
);

	localparam int RW = rabm_pkg::POS_BITS + 1;
	localparam int KW = $clog2(RW);
	localparam int BW = rabm_pkg::BLK_BITS;
	localparam int OW = rabm_pkg::OFF_BITS;

	logic [RW-1:0] r;
	logic [KW-1:0] k;
	logic [KW-1:0] hi;
	logic [KW-1:0] lo;
	logic [RW-1:0] e;
	logic [RW-1:0] b;
	logic [RW-1:0] p;
	logic [BW-1:0] blk;
	logic [OW-1:0] off;
	logic          fire;
	logic          valid_q;

	always_comb begin
		r = {1'b0, job.map_pos} + RW'(1);
		k = '0;
		for (int i = 0; i < RW; i++) begin
			if (r[i]) begin
				k = KW'(i);
			end
		end
		hi  = (k + 1'b1) >> 1;
		lo  = k >> 1;
		e   = r & ((RW'(1) << hi) - RW'(1));
		b   = (r >> hi) & ((RW'(1) << lo) - RW'(1));
		p   = (RW'(1) << hi) + (RW'(1) << lo) - RW'(2);
		blk = job.do_map ? BW'(p + b) : '0;
		off = job.do_map ? e[OW-1:0] : '0;
	end

	assign job_ready = !valid_q || rsp.ready;
	assign fire      = job_valid && job_ready;
	assign rsp.valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (fire) begin
			valid_q <= 1'b1;
		end else if (rsp.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			rsp.block_number  <= blk;
			rsp.block_offset  <= off;
			rsp.value_out     <= job.value;
			rsp.alloc_event   <= job.ev;
			rsp.alloc_block   <= job.ablk;
			rsp.alloc_size    <= job.asize;
			rsp.element_count <= job.count;
			rsp.status        <= job.status;
		end
	end

endmodule

/* hdl/resizable_array_block_mapper_core.sv */
// ---------------------------------------------------------------------------
// Resizable array block mapper core
// Push/pop/locate on a superblock/data block array layout; reports block,
// offset, allocate/free events and element count per item.
// ---------------------------------------------------------------------------
//  channel | dir | handshake    | payload
//  req     | in  | valid/ready  | action, position, write_value
//  rsp     | out | valid/ready  | block_number .. status, one per req item
//
// One item per cycle sustained while rsp does not stall; the req item is
// written into the job queue and then into the output register, where rsp
// turns valid. Rate is set by the layout update in the front end.
// Reset clears the layout state, the job queue pointers and the output valid.
// The job queue holds QUEUE_DEPTH items, so req keeps flowing while rsp stalls
// until the queue is full.
// ---------------------------------------------------------------------------
module resizable_array_block_mapper_core #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic      clk,
	input  logic      arst_n,
	rabm_in_if.sink   req,
	rabm_out_if.source rsp
);

	logic           f_valid;
	logic           f_ready;
	rabm_pkg::job_t f_job;
	logic           b_valid;
	logic           b_ready;
	rabm_pkg::job_t b_job;

	rabm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.job_valid (f_valid),
		.job_ready (f_ready),
		.job       (f_job)
	);

	rabm_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_job   (f_job),
		.pop_valid  (b_valid),
		.pop_ready  (b_ready),
		.pop_job    (b_job)
	);

	rabm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (b_valid),
		.job_ready (b_ready),
		.job       (b_job),
		.rsp       (rsp)
	);

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Block mapper testbench
// Drives push, pop and locate items through the request channel and checks
// every response against a bench model of the array layout, or against the
// want of a typed table row. A short table from reset comes first. Random
// grow/shrink walks follow, and a few pops and a locate close the run.
// ---------------------------------------------------------------------------
module tb_top;

	localparam int CLK_HALF    = 5;
	localparam int IDLE_PCT    = 27;
	localparam int CYCLE_LIMIT = 100_000;
	localparam int RANDOM_ITEMS = 1300;

	localparam int AW    = rabm_pkg::ACT_BITS;
	localparam int PW    = rabm_pkg::POS_BITS;
	localparam int RW    = rabm_pkg::POS_BITS + 1;
	localparam int BLK_W = rabm_pkg::BLK_BITS;
	localparam int OFF_W = rabm_pkg::OFF_BITS;
	localparam int VAL_W = rabm_pkg::VAL_BITS;
	localparam int SZ_W  = rabm_pkg::SIZE_BITS;

	localparam logic [AW-1:0] ACT_POP       = 2'd1;
	localparam logic [AW-1:0] ACT_LOCATE    = 2'd2;
	localparam logic [AW-1:0] ACT_LOCATE_HI = 2'd3;

	typedef struct packed {
		logic [BLK_W-1:0]           block_number;
		logic [OFF_W-1:0]           block_offset;
		logic signed [VAL_W-1:0]    value_out;
		rabm_pkg::alloc_t           alloc_event;
		logic [BLK_W-1:0]           alloc_block;
		logic [SZ_W-1:0]            alloc_size;
		logic [PW-1:0]              element_count;
		rabm_pkg::status_t          status;
	} mapping_t;

	typedef struct {
		logic [AW-1:0]              action;
		logic [PW-1:0]              position;
		logic signed [VAL_W-1:0]    write_value;
		bit                         typed;
		mapping_t                   want;
	} plan_row_t;

	localparam mapping_t NO_MAP = '0;

	plan_row_t plan [0:19] = '{
		'{ACT_POP, 20'd0, 32'sd0, 1'b1,
			'{11'd0, 10'd0, 32'sd0, rabm_pkg::EV_NONE, 11'd0, 11'd0, 20'd0,
				rabm_pkg::ST_EMPTY}},
		'{ACT_LOCATE, 20'd0, 32'sd0, 1'b1,
			'{11'd0, 10'd0, 32'sd0, rabm_pkg::EV_NONE, 11'd0, 11'd0, 20'd0,
				rabm_pkg::ST_RANGE}},
		'{ACT_LOCATE, 20'hFFFFF, 32'sh7FFFFFFF, 1'b1,
			'{11'd0, 10'd0, 32'sd0, rabm_pkg::EV_NONE, 11'd0, 11'd0, 20'd0,
				rabm_pkg::ST_RANGE}},
		'{ACT_LOCATE_HI, 20'd0, 32'sd0, 1'b1,
			'{11'd0, 10'd0, 32'sd0, rabm_pkg::EV_NONE, 11'd0, 11'd0, 20'd0,
				rabm_pkg::ST_RANGE}},
		'{rabm_pkg::ACT_PUSH, 20'hFFFFF, 32'sh7FFFFFFF, 1'b1,
			'{11'd0, 10'd0, 32'sh7FFFFFFF, rabm_pkg::EV_ALLOC, 11'd0, 11'd1, 20'd1,
				rabm_pkg::ST_OK}},
		'{rabm_pkg::ACT_PUSH, 20'd0, 32'sh80000000, 1'b0, NO_MAP},
		'{rabm_pkg::ACT_PUSH, 20'd0, 32'shFFFFFFFF, 1'b0, NO_MAP},
		'{rabm_pkg::ACT_PUSH, 20'd0, 32'sd0, 1'b0, NO_MAP},
		'{ACT_LOCATE, 20'd0, 32'sd0, 1'b0, NO_MAP},
		'{ACT_LOCATE_HI, 20'd3, 32'sd0, 1'b0, NO_MAP},
		'{ACT_LOCATE, 20'd4, 32'sd0, 1'b1,
			'{11'd0, 10'd0, 32'sd0, rabm_pkg::EV_NONE, 11'd0, 11'd0, 20'd4,
				rabm_pkg::ST_RANGE}},
		'{ACT_POP, 20'd0, 32'sd0, 1'b0, NO_MAP},
		'{ACT_POP, 20'hFFFFF, 32'shFFFFFFFF, 1'b0, NO_MAP},
		'{ACT_POP, 20'd0, 32'sd0, 1'b0, NO_MAP},
		'{ACT_POP, 20'd0, 32'sd0, 1'b0, NO_MAP},
		'{ACT_POP, 20'd0, 32'sd0, 1'b1,
			'{11'd0, 10'd0, 32'sd0, rabm_pkg::EV_NONE, 11'd0, 11'd0, 20'd0,
				rabm_pkg::ST_EMPTY}},
		'{rabm_pkg::ACT_PUSH, 20'd0, 32'sh5A5A5A5A, 1'b0, NO_MAP},
		'{rabm_pkg::ACT_PUSH, 20'hFFFFF, 32'shA5A5A5A5, 1'b0, NO_MAP},
		'{ACT_POP, 20'hFFFFF, 32'shFFFFFFFF, 1'b0, NO_MAP},
		'{ACT_LOCATE_HI, 20'd0, 32'shFFFFFFFF, 1'b0, NO_MAP}
	};

	logic clk;
	logic arst_n;
	bit calm;
	int n_errors;
	int unsigned cycles;
	mapping_t expected_maps [$];

	// layout state as the block should hold it
	logic [PW-1:0]                  n_elems;
	logic [rabm_pkg::LVL_BITS-1:0]  sb_level;
	logic [SZ_W-1:0]                tail_blk_size;
	logic [SZ_W-1:0]                tail_blk_fill;
	logic [SZ_W-1:0]                tail_sb_size;
	logic [SZ_W-1:0]                tail_sb_fill;
	logic [rabm_pkg::NBLK_BITS-1:0] n_blocks;
	logic                           have_spare;

	rabm_in_if req_ch ();
	rabm_out_if rsp_ch ();

	resizable_array_block_mapper_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	always #CLK_HALF clk = ~clk;

	function automatic void split_position(input logic [PW-1:0] pos,
		output logic [BLK_W-1:0] blk, output logic [OFF_W-1:0] off);
		logic [RW-1:0] r;
		logic [RW-1:0] e;
		logic [RW-1:0] b;
		logic [RW-1:0] p;
		int k;
		int hi;
		int lo;
		r = {1'b0, pos} + RW'(1);
		k = 0;
		for (int i = 0; i < RW; i++)
			if (r[i])
				k = i;
		hi = (k + 1) / 2;
		lo = k / 2;
		e = r & ((RW'(1) << hi) - RW'(1));
		b = (r >> hi) & ((RW'(1) << lo) - RW'(1));
		p = (RW'(1) << hi) + (RW'(1) << lo) - RW'(2);
		blk = BLK_W'(p + b);
		off = OFF_W'(e);
	endfunction

	function automatic mapping_t predict_step(input logic [AW-1:0] act,
		input logic [PW-1:0] pos, input logic signed [VAL_W-1:0] val);
		mapping_t m;
		m = '0;
		m.status = rabm_pkg::ST_OK;
		m.alloc_event = rabm_pkg::EV_NONE;
		if (act[rabm_pkg::ACT_LOCATE_BIT]) begin
			if (pos >= n_elems)
				m.status = rabm_pkg::ST_RANGE;
			else
				split_position(pos, m.block_number, m.block_offset);
		end else if (act == rabm_pkg::ACT_PUSH) begin
			if (n_elems >= rabm_pkg::CAPACITY) begin
				m.status = rabm_pkg::ST_FULL;
			end else begin
				if (tail_blk_fill >= tail_blk_size) begin
					if (tail_sb_fill >= tail_sb_size) begin
						sb_level++;
						if (sb_level[0])
							tail_sb_size = tail_sb_size << 1;
						else
							tail_blk_size = tail_blk_size << 1;
						tail_sb_fill = '0;
					end
					if (!have_spare) begin
						m.alloc_event = rabm_pkg::EV_ALLOC;
						m.alloc_block = n_blocks[BLK_W-1:0];
						m.alloc_size = tail_blk_size;
					end else begin
						have_spare = 1'b0;
					end
					n_blocks++;
					tail_sb_fill++;
					tail_blk_fill = '0;
				end
				n_elems++;
				tail_blk_fill++;
				split_position(n_elems - 1'b1, m.block_number, m.block_offset);
				m.value_out = val;
			end
		end else begin
			if (n_elems == 0) begin
				m.status = rabm_pkg::ST_EMPTY;
			end else begin
				split_position(n_elems - 1'b1, m.block_number, m.block_offset);
				n_elems--;
				tail_blk_fill--;
				if (tail_blk_fill == 0) begin
					if (have_spare) begin
						m.alloc_event = rabm_pkg::EV_FREE;
						m.alloc_block = n_blocks[BLK_W-1:0];
					end
					n_blocks--;
					tail_sb_fill--;
					have_spare = 1'b1;
					if (sb_level > 1 && tail_sb_fill == 0) begin
						sb_level--;
						if (sb_level[0])
							tail_blk_size = tail_blk_size >> 1;
						else
							tail_sb_size = tail_sb_size >> 1;
						tail_sb_fill = tail_sb_size;
					end
					tail_blk_fill = tail_blk_size;
				end
			end
		end
		m.element_count = n_elems;
		return m;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			n_errors++;
		end
	endtask

	task automatic check_result();
		mapping_t want;
		if (expected_maps.size() == 0) begin
			$error("response with no item pending: block_number %0d", rsp_ch.block_number);
			n_errors++;
		end else begin
			want = expected_maps.pop_front();
			check_field("block_number", 32'(want.block_number), 32'(rsp_ch.block_number));
			check_field("block_offset", 32'(want.block_offset), 32'(rsp_ch.block_offset));
			check_field("value_out", 32'(want.value_out), 32'(rsp_ch.value_out));
			check_field("alloc_event", 32'(want.alloc_event), 32'(rsp_ch.alloc_event));
			check_field("alloc_block", 32'(want.alloc_block), 32'(rsp_ch.alloc_block));
			check_field("alloc_size", 32'(want.alloc_size), 32'(rsp_ch.alloc_size));
			check_field("element_count", 32'(want.element_count),
				32'(rsp_ch.element_count));
			check_field("status", 32'(want.status), 32'(rsp_ch.status));
		end
	endtask

	task automatic send_item(input logic [AW-1:0] act, input logic [PW-1:0] pos,
		input logic signed [VAL_W-1:0] val, input bit typed, input mapping_t want);
		mapping_t guess;
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.action <= act;
		req_ch.position <= pos;
		req_ch.write_value <= val;
		do @(posedge clk); while (!req_ch.ready);
		guess = predict_step(act, pos, val);
		expected_maps.push_back(typed ? want : guess);
	endtask

	task automatic drain();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (expected_maps.size() != 0)
			@(posedge clk);
	endtask

	// alternate grow and shrink walks so the layout climbs and falls through levels
	task automatic random_walk(input int n_items);
		int target;
		int pick;
		bit growing;
		logic [AW-1:0] act;
		logic [PW-1:0] pos;
		growing = 1'b1;
		target = $urandom_range(600, 20);
		for (int i = 0; i < n_items; i++) begin
			calm = (i >= 400 && i < 700);
			pick = $urandom_range(99);
			if (pick < 15) begin
				act = $urandom_range(1) ? ACT_LOCATE : ACT_LOCATE_HI;
				if (n_elems == 0 || $urandom_range(9) == 0)
					pos = PW'($urandom);
				else
					pos = PW'($urandom_range(n_elems - 1));
			end else begin
				act = ((pick < 80) == growing) ? rabm_pkg::ACT_PUSH : ACT_POP;
				pos = PW'($urandom);
			end
			send_item(act, pos, $urandom, 1'b0, NO_MAP);
			if (growing && n_elems >= target) begin
				growing = 1'b0;
			end else if (!growing && n_elems == 0 && $urandom_range(3) == 0) begin
				growing = 1'b1;
				target = $urandom_range(600, 20);
			end
		end
		calm = 1'b0;
	endtask

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready)
				check_result();
			rsp_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
		end else begin
			rsp_ch.ready <= 1'b0;
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		calm = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.action = rabm_pkg::ACT_PUSH;
		req_ch.position = '0;
		req_ch.write_value = '0;
		n_elems = '0;
		sb_level = 6'd1;
		tail_blk_size = 11'd1;
		tail_blk_fill = 11'd1;
		tail_sb_size = 11'd1;
		tail_sb_fill = '0;
		n_blocks = '0;
		have_spare = 1'b0;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i])
			send_item(plan[i].action, plan[i].position, plan[i].write_value,
				plan[i].typed, plan[i].want);
		drain();

		random_walk(RANDOM_ITEMS);
		drain();

		repeat (6)
			send_item(ACT_POP, PW'($urandom), $urandom, 1'b0, NO_MAP);
		send_item(ACT_LOCATE, 20'd0, 32'sd0, 1'b0, NO_MAP);
		drain();

		repeat (8) @(posedge clk);
		if (n_errors == 0 && expected_maps.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule

/* resizable_array_block_mapper_core.f */
+incdir+hdl
hdl/rabm_pkg.sv
hdl/rabm_if.sv
hdl/rabm_front.sv
hdl/rabm_queue.sv
hdl/rabm_back.sv
hdl/resizable_array_block_mapper_core.sv
tb/tb_top.sv
